// File: rtl/bsde_pkg.sv
// Package with shared types and constants of the B-spline de Boor evaluator.
package bsde_pkg;
    localparam logic [1:0] OP_LOAD_KNOT  = 2'd0;
    localparam logic [1:0] OP_LOAD_POINT = 2'd1;
    localparam logic [1:0] OP_EVAL       = 2'd2;
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_RANGE      = 2'd1;
    localparam logic [1:0] ST_INDEX      = 2'd2;
    localparam logic [1:0] CFG_LAST      = 2'd0;
    localparam logic [1:0] CFG_ORDER     = 2'd1;
    localparam logic [1:0] CFG_DIM       = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [6:0]         index;
        logic signed [31:0] knot_value;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] param_t;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [1:0]         status;
    } t_out_word;
endpackage

// File: rtl/bsde_divider.sv
// Restoring divider producing a saturated truncated fixed-point quotient.
module bsde_divider import bsde_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    localparam int NW = 33 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q, n_q;
    logic [33:0]   r_rem, n_rem;
    logic [32:0]   r_d;
    logic          r_neg, r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [34:0]   w_trial;
    logic [NW-1:0] w_mag;
    logic [32:0]   w_na, w_da;

    assign w_na = i_num[32] ? 33'(-i_num) : 33'(i_num);
    assign w_da = i_den[32] ? 33'(-i_den) : 33'(i_den);
    assign w_trial = {r_rem, r_q[NW-1]} - {2'b0, r_d};

    always_comb begin
        n_rem = r_rem;
        n_q = {r_q[NW-2:0], 1'b0};
        if (!w_trial[34]) begin
            n_rem = w_trial[33:0];
            n_q[0] = 1'b1;
        end else begin
            n_rem = {r_rem[32:0], r_q[NW-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q <= {w_na, {FRAC_BITS{1'b0}}};
                r_rem <= '0;
                r_d <= w_da;
                r_neg <= i_num[32] ^ i_den[32];
                r_cnt <= CW'(NW);
            end else if (r_busy) begin
                r_q <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign w_mag = r_q;
    always_comb begin
        if (!r_neg) begin
            o_quot = (w_mag > NW'(32'h7fffffff)) ? 32'sh7fffffff : 32'(w_mag);
        end else begin
            o_quot = (w_mag > NW'(33'h80000000)) ? 32'sh80000000 : 32'(-w_mag);
        end
    end
    assign o_done = r_done;
endmodule

// File: rtl/bspline_de_boor_evaluator.sv
// Top level of the B-spline de Boor evaluator with knot and point memories.
// Loads are checked in S_CHK, which registers their result word. An
// evaluation searches the knot span one memory read per step, then for each
// of the k(k-1)/2 triangle entries reads two knots, runs a serial divide
// unless the two knots are equal and blends three coordinates with one
// multiplier. Results appear for one cycle on o_result_valid and must be
// taken then; busy falls in the cycle in which the word is shown.
module bspline_de_boor_evaluator import bsde_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_ORDER  = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_word   i_item,
    output logic       o_result_valid,
    output t_out_word  o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int KD = MAX_POINTS + MAX_ORDER;
    localparam int KA = $clog2(KD);
    localparam int PA = $clog2(MAX_POINTS);
    localparam int WA = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_RDE = 4'd2,
        S_ENDW = 4'd3, S_RLO = 4'd4, S_RHI = 4'd5, S_SRCH = 4'd6, S_SRW = 4'd7,
        S_CPY = 4'd8, S_KA = 4'd9, S_KB = 4'd10, S_DIV = 4'd11,
        S_BL = 4'd12, S_OUT = 4'd13, S_KW = 4'd14, S_CPW = 4'd15;

    logic signed [31:0] knot_mem [KD];
    logic [95:0]        point_mem [MAX_POINTS];
    logic [95:0]        work_mem [MAX_ORDER];

    logic [3:0]  r_state;
    logic [5:0]  r_n;
    logic [3:0]  r_k;
    logic [1:0]  r_dim;
    t_in_word    r_in;
    logic [KA:0] r_lo, r_hi, r_mid, r_span;
    logic [KA-1:0] r_kaddr;
    logic signed [31:0] r_kdata, r_ki;
    logic [PA-1:0] r_paddr;
    logic [95:0] r_pdata, r_wa, r_wb;
    logic [WA-1:0] r_waddr;
    logic [4:0]  r_r, r_s, r_ci;
    logic [1:0]  r_c;
    logic        r_wrd;
    logic signed [31:0] r_f;
    logic        r_dstart;
    logic signed [32:0] r_num, r_den;
    logic        w_ddone;
    logic signed [31:0] w_quot;
    logic        r_ov;
    t_out_word   r_out;
    logic signed [63:0] r_prod;
    logic [1:0]  r_bph;

    bsde_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_num), .i_den(r_den), .o_done(w_ddone), .o_quot(w_quot));

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_result_valid = r_ov;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        r_kdata <= knot_mem[r_kaddr];
        r_pdata <= point_mem[r_paddr];
    end

    logic signed [31:0] w_a, w_b;
    logic signed [32:0] w_d;
    logic signed [64:0] w_sum;
    logic signed [31:0] w_bl;
    always_comb begin
        w_a = $signed(r_wa[95-32*r_c -: 32]);
        w_b = $signed(r_wb[95-32*r_c -: 32]);
        w_d = 33'(w_b) - 33'(w_a);
        w_sum = 65'(w_a) + 65'(r_prod >>> FRAC_BITS);
        if (w_sum > 65'sh7fffffff) w_bl = 32'sh7fffffff;
        else if (w_sum < -65'sh80000000) w_bl = 32'sh80000000;
        else w_bl = 32'(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n <= 6'd3;
            r_k <= 4'd4;
            r_dim <= 2'd3;
            r_ov <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_ov <= 1'b0;
            r_dstart <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LAST:  r_n <= i_cfg_data[5:0];
                    CFG_ORDER: r_k <= i_cfg_data[3:0];
                    CFG_DIM:   r_dim <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: if (start) begin
                    r_in <= i_item;
                    r_out <= '0;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= S_IDLE;
                    r_ov <= 1'b1;
                    case (r_in.operation)
                        OP_LOAD_KNOT: begin
                            if (32'(r_in.index) >= 32'(KD)) r_out.status <= ST_INDEX;
                            else knot_mem[KA'(r_in.index)] <= r_in.knot_value;
                        end
                        OP_LOAD_POINT: begin
                            if (32'(r_in.index) >= 32'(MAX_POINTS)) r_out.status <= ST_INDEX;
                            else point_mem[PA'(r_in.index)] <=
                                {r_in.coord_x, r_in.coord_y, r_in.coord_z};
                        end
                        OP_EVAL: begin
                            if (r_k == 0 || 32'(r_k) > 32'(MAX_ORDER) ||
                                    {1'b0, r_n} + 7'd1 < {3'b0, r_k} ||
                                    32'(r_n) >= 32'(MAX_POINTS)) begin
                                r_out.status <= ST_RANGE;
                            end else begin
                                r_ov <= 1'b0;
                                r_kaddr <= KA'({1'b0, r_n} + 7'd1);
                                r_state <= S_RDE;
                            end
                        end
                        default: ;
                    endcase
                end
                S_RDE: r_state <= S_ENDW;
                S_ENDW: begin
                    if (r_in.param_t == r_kdata) begin
                        r_span <= (KA+1)'(r_n);
                        r_state <= S_CPY;
                        r_ci <= '0;
                        r_paddr <= PA'(r_n + 6'd1 - 6'(r_k));
                    end else if (r_in.param_t > r_kdata) begin
                        r_out.status <= ST_RANGE;
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_lo <= (KA+1)'(r_k - 4'd1);
                        r_hi <= (KA+1)'({1'b0, r_n} + 7'd1);
                        r_kaddr <= KA'(r_k - 4'd1);
                        r_state <= S_RLO;
                    end
                end
                S_RLO: r_state <= S_RHI;
                S_RHI: begin
                    if (r_in.param_t < r_kdata) begin
                        r_out.status <= ST_RANGE;
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_hi - r_lo > 1) begin
                        r_mid <= (r_lo + r_hi) >> 1;
                        r_kaddr <= KA'((r_lo + r_hi) >> 1);
                        r_state <= S_SRW;
                        r_wrd <= 1'b0;
                    end else begin
                        r_span <= r_lo;
                        r_ci <= '0;
                        r_paddr <= PA'(r_lo + 1 - (KA+1)'(r_k));
                        r_state <= S_CPY;
                    end
                end
                S_SRW: begin
                    r_wrd <= 1'b1;
                    if (r_wrd) begin
                        if (r_in.param_t < r_kdata) r_hi <= r_mid;
                        else r_lo <= r_mid;
                        r_state <= S_SRCH;
                    end
                end
                S_CPY: r_state <= S_CPW;
                S_CPW: begin
                    work_mem[WA'(r_ci)] <= r_pdata;
                    if (r_ci + 1 == 5'(r_k)) begin
                        r_r <= 5'd1;
                        r_s <= '0;
                        r_wrd <= 1'b0;
                        r_state <= (r_k == 4'd1) ? S_OUT : S_KA;
                    end else begin
                        r_ci <= r_ci + 1'b1;
                        r_paddr <= r_paddr + 1'b1;
                        r_state <= S_CPY;
                    end
                end
                S_KA: begin
                    // i = base + r + s; read knot[i] then knot[i+k-r].
                    r_kaddr <= KA'(r_span + 1 - (KA+1)'(r_k) + (KA+1)'(r_r)
                        + (KA+1)'(r_s));
                    r_wrd <= 1'b0;
                    r_state <= S_KW;
                end
                S_KW: begin
                    if (r_wrd) begin
                        r_ki <= r_kdata;
                        r_kaddr <= KA'(r_span + 1 + (KA+1)'(r_s));
                        r_wrd <= 1'b0;
                        r_state <= S_KB;
                    end else r_wrd <= 1'b1;
                end
                S_KB: begin
                    r_wrd <= 1'b1;
                    if (r_wrd) begin
                        r_num <= 33'(r_in.param_t) - 33'(r_ki);
                        r_den <= 33'(r_kdata) - 33'(r_ki);
                        if (r_kdata == r_ki) begin
                            r_f <= '0;
                            r_state <= S_BL;
                            r_c <= '0;
                            r_bph <= '0;
                        end else begin
                            r_dstart <= 1'b1;
                            r_state <= S_DIV;
                        end
                        r_waddr <= WA'(r_s);
                    end
                end
                S_DIV: if (w_ddone) begin
                    r_f <= w_quot;
                    r_state <= S_BL;
                    r_c <= '0;
                    r_bph <= '0;
                end
                S_BL: begin
                    case (r_bph)
                        2'd0: begin
                            r_wa <= work_mem[r_waddr];
                            r_bph <= 2'd1;
                        end
                        2'd1: begin
                            r_wb <= work_mem[WA'(r_s + 1)];
                            r_bph <= 2'd2;
                        end
                        2'd2: begin
                            r_prod <= 64'(r_f) * 64'(w_d);
                            r_bph <= 2'd3;
                        end
                        default: begin
                            r_wa[95-32*r_c -: 32] <= w_bl;
                            if (r_c == 2'd2) begin
                                work_mem[r_waddr] <= {r_wa[95:32], w_bl};
                                if (32'(r_s) + 32'(r_r) + 1 >= 32'(r_k)) begin
                                    if (32'(r_r) + 1 >= 32'(r_k)) begin
                                        r_wrd <= 1'b0;
                                        r_state <= S_OUT;
                                    end else begin
                                        r_r <= r_r + 1'b1;
                                        r_s <= '0;
                                        r_state <= S_KA;
                                    end
                                end else begin
                                    r_s <= r_s + 1'b1;
                                    r_state <= S_KA;
                                end
                            end else begin
                                r_c <= r_c + 1'b1;
                                r_bph <= 2'd2;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    r_wa <= work_mem[0];
                    if (r_wrd) begin
                        r_wrd <= 1'b0;
                        r_out.point_x <= r_wa[95:64];
                        r_out.point_y <= r_wa[63:32];
                        r_out.point_z <= (r_dim == 2'd2) ? '0 : r_wa[31:0];
                        r_out.status <= ST_OK;
                        r_ov <= 1'b1;
                        r_state <= S_IDLE;
                    end else r_wrd <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && r_in.operation != OP_EVAL) |=> r_ov)
        else $error("load word late");
    a_ov_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_state == S_IDLE)
        else $error("result while busy");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");
endmodule
